// ===== src/clock_block_cache_tags_defines.svh =====
// Assertion macros shared by the clock block cache tag engine.
// No dependencies; included by the files that carry assertions.
`ifndef CLOCK_BLOCK_CACHE_TAGS_DEFINES_SVH
`define CLOCK_BLOCK_CACHE_TAGS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cbct_pkg.sv =====
// Types and constants of the clock block cache tag engine.
// No dependencies; imported by clock_block_cache_tags and the testbench.
package cbct_pkg;

  localparam int ENTRIES     = 64;
  localparam int BLOCK_BYTES = 512;

  localparam int ENTRY_W = $clog2(ENTRIES);
  localparam int SCAN_W  = ENTRY_W + 1;
  localparam int OFF_W   = $clog2(BLOCK_BYTES);
  localparam int TAG_W   = 32;
  localparam int POS_W   = 41;
  localparam int LEN_W   = 16;
  localparam int GLEN_W  = 10;

  // input tdata layout
  localparam int IN_POS_LSB = 0;
  localparam int IN_LEN_LSB = IN_POS_LSB + POS_W;
  localparam int IN_DATA_W  = 64;

  // output tdata layout
  localparam int OUT_HIT_LSB  = 0;
  localparam int OUT_SLOT_LSB = OUT_HIT_LSB + 1;
  localparam int OUT_FILL_LSB = OUT_SLOT_LSB + ENTRY_W;
  localparam int OUT_WB_LSB   = OUT_FILL_LSB + 1;
  localparam int OUT_BLK_LSB  = OUT_WB_LSB + 1;
  localparam int OUT_GLEN_LSB = OUT_BLK_LSB + TAG_W;
  localparam int OUT_USED_W   = OUT_GLEN_LSB + GLEN_W;
  localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cbct_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_DONE
  } cbct_state_t;

endpackage

// ===== src/clock_block_cache_tags.sv =====
// Clock (second chance) tag and replacement engine of a block cache.
// Single access transaction in, one result transaction out; latency is set by the
// tag memory scan and the clock walk. A hit on entry k ends the scan at that entry;
// a miss scans all 64 tags, then walks the used bits one slot a cycle until it finds
// a clear used bit, which marks the victim slot. The tag memory has
// one read port, read once a cycle during the scan. A new access is taken only when
// the previous one has finished; a finished result waits in the output register.
// Depends on cbct_pkg and clock_block_cache_tags_defines.svh.
`include "clock_block_cache_tags_defines.svh"

module clock_block_cache_tags
  import cbct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [40:0] byte_pos, [56:41] req_len, [63:57] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] cmd
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] hit, [6:1] slot, [7] fill_needed, [8] write_back, [40:9] block_number,
  // [50:41] granted_len, [55:51] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cbct_state_t state_r, state_nxt;

  logic [TAG_W-1:0]   tag_mem [ENTRIES];
  logic [TAG_W-1:0]   rd_data_r;
  logic               mem_we;

  logic [SCAN_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic [ENTRY_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENTRIES-1:0] used_r, used_nxt;
  logic [ENTRY_W-1:0] ptr_r, ptr_nxt;
  cbct_cmd_t          cmd_r, cmd_nxt;
  logic [TAG_W-1:0]   blk_r, blk_nxt;
  logic [GLEN_W-1:0]  glen_r, glen_nxt;
  logic               hit_r, hit_nxt;
  logic [ENTRY_W-1:0] slot_r, slot_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [POS_W-1:0]   in_pos;
  logic [LEN_W-1:0]   in_len;
  logic [GLEN_W-1:0]  room;
  logic               tag_match;
  logic               scan_last;
  logic               out_free;

  assign in_pos    = in_tdata[IN_POS_LSB +: POS_W];
  assign in_len    = in_tdata[IN_LEN_LSB +: LEN_W];
  assign room      = GLEN_W'(BLOCK_BYTES) - GLEN_W'(in_pos[OFF_W-1:0]);
  assign tag_match = cmp_vld_r && valid_r[cmp_idx_r] && (rd_data_r == blk_r);
  assign scan_last = cmp_vld_r && (cmp_idx_r == ENTRY_W'(ENTRIES - 1));
  assign out_free  = !out_tvalid_r || out_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (tag_match) begin
          state_nxt = ST_DONE;
        end else if (scan_last) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: if (!used_r[ptr_r]) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    scan_addr_nxt  = scan_addr_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    valid_nxt      = valid_r;
    used_nxt       = used_r;
    ptr_nxt        = ptr_r;
    cmd_nxt        = cmd_r;
    blk_nxt        = blk_r;
    glen_nxt       = glen_r;
    hit_nxt        = hit_r;
    slot_nxt       = slot_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mem_we         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt       = cbct_cmd_t'(in_tuser);
          blk_nxt       = in_pos[OFF_W +: TAG_W];
          glen_nxt      = (in_len > LEN_W'(room)) ? room : in_len[GLEN_W-1:0];
          scan_addr_nxt = '0;
          cmp_vld_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        // issue one tag read a cycle, compare the registered data next cycle
        if (scan_addr_r < SCAN_W'(ENTRIES)) begin
          scan_addr_nxt = scan_addr_r + SCAN_W'(1);
          cmp_idx_nxt   = scan_addr_r[ENTRY_W-1:0];
          cmp_vld_nxt   = 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (tag_match) begin
          hit_nxt             = 1'b1;
          slot_nxt            = cmp_idx_r;
          used_nxt[cmp_idx_r] = 1'b1;
        end
      end
      ST_WALK: begin
        if (used_r[ptr_r]) begin
          // second chance: clear and advance
          used_nxt[ptr_r] = 1'b0;
          ptr_nxt = (ptr_r == ENTRY_W'(ENTRIES - 1)) ? '0 : ptr_r + ENTRY_W'(1);
        end else begin
          mem_we           = 1'b1;
          valid_nxt[ptr_r] = 1'b1;
          used_nxt[ptr_r]  = 1'b1;
          hit_nxt          = 1'b0;
          slot_nxt         = ptr_r;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = '0;
          out_tdata_nxt[OUT_HIT_LSB]                = hit_r;
          out_tdata_nxt[OUT_SLOT_LSB +: ENTRY_W]    = slot_r;
          out_tdata_nxt[OUT_FILL_LSB]               = !hit_r;
          out_tdata_nxt[OUT_WB_LSB]                 = (cmd_r == CMD_WRITE);
          out_tdata_nxt[OUT_BLK_LSB +: TAG_W]       = blk_r;
          out_tdata_nxt[OUT_GLEN_LSB +: GLEN_W]     = glen_r;
        end
      end
      default: ;
    endcase
  end

  // tag memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[ptr_r] <= blk_r;
    end
    rd_data_r <= tag_mem[scan_addr_r[ENTRY_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cmp_vld_r    <= 1'b0;
      valid_r      <= '0;
      used_r       <= '0;
      ptr_r        <= '0;
      out_tvalid_r <= 1'b0;
      scan_addr_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      valid_r      <= valid_nxt;
      used_r       <= used_nxt;
      ptr_r        <= ptr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      scan_addr_r  <= scan_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    cmd_r       <= cmd_nxt;
    blk_r       <= blk_nxt;
    glen_r      <= glen_nxt;
    hit_r       <= hit_nxt;
    slot_r      <= slot_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  `CBCT_ASSERT_NOW(a_done_slot_live, state_r == ST_DONE, valid_r[slot_r] && used_r[slot_r], "result slot not valid and used")
  `CBCT_ASSERT_NOW(a_miss_at_pointer, state_r == ST_DONE && !hit_r, slot_r == ptr_r, "miss slot differs from clock pointer")
  `CBCT_ASSERT_NOW(a_scan_pairing, state_r == ST_SCAN && cmp_vld_r, SCAN_W'(cmp_idx_r) + SCAN_W'(1) == scan_addr_r, "compare index out of step with read address")
  `CBCT_ASSERT_NEXT(a_walk_stops, state_r == ST_WALK && !used_r[ptr_r], state_r == ST_DONE && valid_r[$past(ptr_r)], "walk did not fill the victim slot")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for clock_block_cache_tags: streams read and write accesses through the
// block and checks each result against a second-chance cache tracker in the scoreboard.
// Depends on cbct_pkg and the clock_block_cache_tags RTL.
module tb;
  import cbct_pkg::*;

  typedef struct {
    logic               hit;
    logic [ENTRY_W-1:0] slot;
    logic               fill;
    logic               wb;
    logic [TAG_W-1:0]   blk;
    logic [GLEN_W-1:0]  glen;
  } cache_result_t;

  // Tracks tags, valid and used bits and the clock hand; queues the outcome of each access.
  class clock_cache_tracker;
    logic [TAG_W-1:0] tags[ENTRIES];
    bit               valid_bits[ENTRIES];
    bit               used_bits[ENTRIES];
    int unsigned      hand;
    cache_result_t    pending_results[$];
    int unsigned      mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        tags[i] = '0;
        valid_bits[i] = 1'b0;
        used_bits[i] = 1'b0;
      end
      hand = 0;
      mismatches = 0;
    endfunction

    function void note_access(cbct_cmd_t cmd, logic [POS_W-1:0] pos, logic [LEN_W-1:0] len);
      cache_result_t outcome;
      longint unsigned blk_wide;
      longint unsigned room;
      int unsigned idx;
      bit found;
      blk_wide = longint'(pos) / BLOCK_BYTES;
      room = BLOCK_BYTES - (longint'(pos) % BLOCK_BYTES);
      found = 1'b0;
      idx = 0;
      outcome.blk = blk_wide[TAG_W-1:0];
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && valid_bits[i] && tags[i] == outcome.blk) begin
          found = 1'b1;
          idx = i;
        end
      end
      if (found) begin
        used_bits[idx] = 1'b1;
      end else begin
        // second chance: clear used bits until a clear one turns up
        hand = hand % ENTRIES;
        for (int steps = 0; steps <= ENTRIES; steps++) begin
          if (!used_bits[hand]) break;
          used_bits[hand] = 1'b0;
          hand = (hand + 1) % ENTRIES;
        end
        idx = hand;
        tags[idx] = outcome.blk;
        valid_bits[idx] = 1'b1;
        used_bits[idx] = 1'b1;
      end
      outcome.hit = found;
      outcome.slot = idx[ENTRY_W-1:0];
      outcome.fill = !found;
      outcome.wb = (cmd == CMD_WRITE);
      outcome.glen = (longint'(len) > room) ? room[GLEN_W-1:0] : len[GLEN_W-1:0];
      pending_results.push_back(outcome);
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: mismatch on %s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      cache_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: result with nothing outstanding: %h", data);
        return;
      end
      want = pending_results.pop_front();
      compare("hit", want.hit, data[OUT_HIT_LSB]);
      compare("slot", want.slot, data[OUT_SLOT_LSB +: ENTRY_W]);
      compare("fill_needed", want.fill, data[OUT_FILL_LSB]);
      compare("write_back", want.wb, data[OUT_WB_LSB]);
      compare("block_number", want.blk, data[OUT_BLK_LSB +: TAG_W]);
      compare("granted_len", want.glen, data[OUT_GLEN_LSB +: GLEN_W]);
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  localparam int TOTAL_ACCESSES = 1650;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  clock_cache_tracker tracker = new();
  int unsigned        sent = 0;
  bit                 calm = 1'b0;

  clock_block_cache_tags i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check each transaction, stall at random outside the calm stretch.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
    out_tready <= calm || ($urandom_range(99) >= 38);
  end

  function automatic logic [POS_W-1:0] pos_of(logic [TAG_W-1:0] blk, int unsigned off);
    logic [POS_W-1:0] pos;
    pos = {blk, 9'd0};
    pos = pos | (POS_W'(off) % BLOCK_BYTES);
    return pos;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len(logic [POS_W-1:0] pos);
    int unsigned room;
    room = BLOCK_BYTES - int'(pos % BLOCK_BYTES);
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return LEN_W'(room);
      3: return LEN_W'(room + 1);
      4: return LEN_W'($urandom_range(1, 600));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_off();
    case ($urandom_range(3))
      0: return 0;
      1: return BLOCK_BYTES - 1;
      default: return $urandom_range(BLOCK_BYTES - 1);
    endcase
  endfunction

  task automatic send(cbct_cmd_t cmd, logic [POS_W-1:0] pos, logic [LEN_W-1:0] len);
    logic [IN_DATA_W-1:0] data;
    if (!calm) begin
      while ($urandom_range(99) < 38) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    data = '0;
    data[IN_POS_LSB +: POS_W] = pos;
    data[IN_LEN_LSB +: LEN_W] = len;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_access(cmd, pos, len);
    sent++;
    calm = (sent >= 800 && sent < 1000);
  endtask

  task automatic send_random(logic [TAG_W-1:0] blk);
    logic [POS_W-1:0] pos;
    pos = pos_of(blk, pick_off());
    send(cbct_cmd_t'($urandom_range(1)), pos, pick_len(pos));
  endtask

  task automatic wait_drained();
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    logic [TAG_W-1:0] base;
    int unsigned      pool;
    int unsigned      count;
    int unsigned      sel;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, clamping, zero length, hits after fills
    send(CMD_READ, '0, '0);
    send(CMD_WRITE, '0, '1);
    send(CMD_READ, '1, '1);
    send(CMD_WRITE, POS_W'(511), LEN_W'(1));
    send(CMD_READ, POS_W'(512), LEN_W'(512));
    send(CMD_READ, POS_W'(1000), LEN_W'(24));
    send(CMD_WRITE, pos_of(32'h5555_5555, 100), LEN_W'(412));
    send(CMD_READ, pos_of(32'h5555_5555, 100), LEN_W'(413));
    send(CMD_READ, pos_of(32'hAAAA_AAAA, 9'h0AA), 16'h5555);
    send(CMD_WRITE, pos_of(32'hAAAA_AAAA, 0), '0);
    send(CMD_READ, pos_of(32'hFFFF_FFFF, 9'h155), 16'hAAAA);
    send(CMD_WRITE, pos_of(32'h0000_0001, 511), 16'h8000);

    // hold off until the block has drained everything
    in_tvalid <= 1'b0;
    wait_drained();

    while (sent < TOTAL_ACCESSES) begin
      sel = $urandom_range(99);
      base = $urandom;
      if (sel < 8) begin
        // fill the ring, hit every entry, then miss: forces a full walk
        for (int r = 0; r < 2; r++)
          for (int k = 0; k < ENTRIES; k++) send_random(base + TAG_W'(k));
        send_random(base + TAG_W'(ENTRIES));
      end else if (sel < 20) begin
        count = $urandom_range(1, 5);
        repeat (count) begin
          send(cbct_cmd_t'($urandom_range(1)), POS_W'({$urandom, $urandom}), LEN_W'($urandom));
        end
      end else begin
        case ($urandom_range(3))
          0: pool = 4;
          1: pool = 32;
          2: pool = 64;
          default: pool = 96;
        endcase
        count = $urandom_range(10, 40);
        repeat (count) send_random(base + TAG_W'($urandom_range(pool - 1)));
      end
    end
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/cbct_pkg.sv
src/clock_block_cache_tags.sv
test/tb.sv
